### hw/rtl/hsl_to_rgb_converter_assert.svh
// Assertion macros used by the checker of the HSL to RGB converter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSL2RGB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication that stays active through reset.
`define HSL2RGB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/hsl2rgb_pkg.sv
// Package of the HSL to RGB converter: fixed-point constants, beat types and helpers.
// Depends on nothing; the front end, back end, top level and checker import it.
package hsl2rgb_pkg;

  localparam int FRAC_BITS = 12;
  localparam int HUE_W     = FRAC_BITS;
  localparam int ONE_W     = FRAC_BITS + 1;

  typedef logic [HUE_W-1:0] hue_t;
  typedef logic [ONE_W-1:0] unit_t;

  localparam unit_t ONE        = unit_t'(1 << FRAC_BITS);
  localparam hue_t  HALF       = hue_t'((1 << FRAC_BITS) / 2);
  localparam hue_t  THIRD      = hue_t'((1 << FRAC_BITS) / 3);
  localparam hue_t  SIXTH      = hue_t'((1 << FRAC_BITS) / 6);
  localparam hue_t  TWO_THIRDS = hue_t'((2 << FRAC_BITS) / 3);

  localparam int HSL2RGB_MID_DEPTH = 4;
  localparam int HSL2RGB_OUT_DEPTH = 2;

  typedef struct packed {
    hue_t  hue;
    unit_t saturation;
    unit_t lightness;
  } hsl2rgb_in_t;

  typedef struct packed {
    unit_t red;
    unit_t green;
    unit_t blue;
  } hsl2rgb_out_t;

  // Classified pixel handed from the front to the back. Ramp positions are
  // ordered red, green, blue.
  typedef struct packed {
    logic                 gray;
    unit_t                lightness;
    unit_t                p;
    unit_t                q;
    logic [2:0][HUE_W-1:0] pos;
  } hsl2rgb_mid_t;

  function automatic unit_t sat_one(input unit_t v);
    sat_one = (v > ONE) ? ONE : v;
  endfunction

endpackage

### hw/rtl/hsl2rgb_queue.sv
// Small first-in first-out queue of register entries with push/full and pop/empty sides.
// Depends on nothing; DEPTH must be a power of two of at least two.
module hsl2rgb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hw/rtl/hsl2rgb_front.sv
// Front end of the HSL to RGB converter: accepts pixels, flags gray ones and forms q, p
// and the three ramp positions. Depends on hsl2rgb_pkg.
module hsl2rgb_front
  import hsl2rgb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_push,
  output logic         in_full,
  input  hsl2rgb_in_t  in_data,
  output logic         mid_push,
  input  logic         mid_full,
  output hsl2rgb_mid_t mid_data
);

  localparam int PROD_W = 2 * ONE_W + 1;

  logic                  s1_v_r, s1_v_nxt;
  logic                  gray_r;
  unit_t                 l_r, q_r;
  logic [2:0][HUE_W-1:0] pos_r;

  logic                  advance, accept;
  unit_t                 s, l;
  logic                  low;
  logic [ONE_W:0]        mult_b;
  logic [PROD_W-1:0]     prod, prod_rnd;
  logic [ONE_W:0]        rnd;
  logic [ONE_W+1:0]      q_wide;
  logic [ONE_W:0]        p_wide;

  assign advance  = !s1_v_r || !mid_full;
  assign in_full  = !advance;
  assign accept   = in_push && advance;
  assign mid_push = s1_v_r && !mid_full;
  assign s1_v_nxt = advance ? accept : s1_v_r;

  // q = L*(1+S) below half lightness, otherwise L + S - L*S.
  always_comb begin
    s        = sat_one(in_data.saturation);
    l        = sat_one(in_data.lightness);
    low      = (l < unit_t'(HALF));
    mult_b   = low ? ({1'b0, s} + {1'b0, ONE}) : {1'b0, s};
    prod     = PROD_W'(l) * PROD_W'(mult_b);
    prod_rnd = prod + PROD_W'(HALF);
    rnd      = prod_rnd[FRAC_BITS +: ONE_W+1];
    q_wide   = low ? (ONE_W+2)'(rnd)
                   : (ONE_W+2)'(l) + (ONE_W+2)'(s) - (ONE_W+2)'(rnd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // Hue positions wrap modulo one turn, which the hue width does by itself.
  always_ff @(posedge clk) begin
    if (accept) begin
      gray_r   <= (s == '0);
      l_r      <= l;
      q_r      <= q_wide[ONE_W-1:0];
      pos_r[0] <= in_data.hue + THIRD;
      pos_r[1] <= in_data.hue;
      pos_r[2] <= in_data.hue - THIRD;
    end
  end

  always_comb begin
    p_wide             = {l_r, 1'b0} - (ONE_W+1)'(q_r);
    mid_data.gray      = gray_r;
    mid_data.lightness = l_r;
    mid_data.q         = q_r;
    mid_data.p         = p_wide[ONE_W-1:0];
    mid_data.pos       = pos_r;
  end

endmodule

### hw/rtl/hsl2rgb_back.sv
// Back end of the HSL to RGB converter: evaluates the hue ramp for red, green and blue
// in two steps, one multiplier per channel. Depends on hsl2rgb_pkg.
module hsl2rgb_back
  import hsl2rgb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         mid_empty,
  output logic         mid_pop,
  input  hsl2rgb_mid_t mid_data,
  output logic         out_push,
  input  logic         out_full,
  output hsl2rgb_out_t out_data
);

  localparam int PRW = ONE_W + HUE_W;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

  logic              b1_v_r, b1_v_nxt;
  logic              gray_r;
  unit_t             l_r, p_r, q_r;
  seg_t              seg_r  [3];
  logic [PRW-1:0]    prod_r [3];

  logic              advance;
  unit_t             d;
  seg_t              seg    [3];
  hue_t              arg    [3];
  hue_t              fall_t [3];
  logic [HUE_W+2:0]  arg_w  [3];
  logic [PRW-1:0]    prod_rnd [3];
  logic [ONE_W:0]    val    [3];
  unit_t             chan   [3];

  assign advance  = !b1_v_r || !out_full;
  assign mid_pop  = !mid_empty && advance;
  assign out_push = b1_v_r && !out_full;
  assign b1_v_nxt = advance ? mid_pop : b1_v_r;
  assign d        = mid_data.q - mid_data.p;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fall_t[i] = TWO_THIRDS - mid_data.pos[i];
      if (mid_data.pos[i] < SIXTH) begin
        seg[i]   = SEG_RISE;
        arg_w[i] = (HUE_W+3)'(mid_data.pos[i]) * (HUE_W+3)'(6);
      end else if (mid_data.pos[i] < HALF) begin
        seg[i]   = SEG_HIGH;
        arg_w[i] = '0;
      end else if (mid_data.pos[i] < TWO_THIRDS) begin
        seg[i]   = SEG_FALL;
        arg_w[i] = (HUE_W+3)'(fall_t[i]) * (HUE_W+3)'(6);
      end else begin
        seg[i]   = SEG_LOW;
        arg_w[i] = '0;
      end
      arg[i] = arg_w[i][HUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else begin
      b1_v_r <= b1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      gray_r <= mid_data.gray;
      l_r    <= mid_data.lightness;
      p_r    <= mid_data.p;
      q_r    <= mid_data.q;
      for (int i = 0; i < 3; i++) begin
        seg_r[i]  <= seg[i];
        prod_r[i] <= PRW'(d) * PRW'(arg[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_rnd[i] = prod_r[i] + PRW'(HALF);
      case (seg_r[i])
        SEG_RISE, SEG_FALL: val[i] = {1'b0, p_r} + {1'b0, prod_rnd[i][FRAC_BITS +: ONE_W]};
        SEG_HIGH:           val[i] = {1'b0, q_r};
        SEG_LOW:            val[i] = {1'b0, p_r};
        default:            val[i] = {1'b0, p_r};
      endcase
      if (gray_r) begin
        chan[i] = l_r;
      end else if (val[i] > {1'b0, ONE}) begin
        chan[i] = ONE;
      end else begin
        chan[i] = val[i][ONE_W-1:0];
      end
    end
    out_data.red   = chan[0];
    out_data.green = chan[1];
    out_data.blue  = chan[2];
  end

endmodule

### hw/rtl/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB converter: front end, decoupling queue, back end, result queue.
// Depends on hsl2rgb_pkg, hsl2rgb_queue, hsl2rgb_front and hsl2rgb_back.
//
// Usage: pixels enter as hue, saturation and lightness in 12-fractional-bit fixed point
// (4096 is 1.0, hue is a fraction of a turn) and leave as red, green and blue, each
// rounded and saturated to 0..4096. A zero saturation gives gray at the lightness level.
// Both channels behave like queues. An input beat is taken when in_push is high and in_full
// is low; the oldest result sits on out_data while out_empty is low and is taken when
// out_pop is high. Exactly one result beat leaves for every input beat, in order.
// Path: a taken pixel is registered in the front stage, queued, registered in the back
// stage and queued again for out_data. Throughput is one pixel per clock when nothing
// stalls downstream; the front q multiply and the three back ramp multipliers feed registers.
// The front end and back end are separated by a queue of MID_DEPTH entries and the results
// wait in a queue of OUT_DEPTH entries, so a receiver that holds off out_pop fills these
// queues first; in_full rises only once the front stage cannot drain.
// Reset (rst_n low at a clock edge) empties both queues and both stages: out_empty goes
// high and in_full low after the edge. No clearing pass is needed afterward.
module hsl_to_rgb_converter
  import hsl2rgb_pkg::*;
#(
  parameter int MID_DEPTH = HSL2RGB_MID_DEPTH,
  parameter int OUT_DEPTH = HSL2RGB_OUT_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_push,
  output logic         in_full,
  input  hsl2rgb_in_t  in_data,
  output logic         out_empty,
  input  logic         out_pop,
  output hsl2rgb_out_t out_data
);

  localparam int MID_W = $bits(hsl2rgb_mid_t);
  localparam int OUT_W = $bits(hsl2rgb_out_t);

  // Front to queue.
  logic         fq_push, fq_full;
  hsl2rgb_mid_t fq_data;
  // Queue to back.
  logic         qb_pop, qb_empty;
  logic [MID_W-1:0] qb_bits;
  hsl2rgb_mid_t qb_data;
  // Back to result queue.
  logic         bo_push, bo_full;
  hsl2rgb_out_t bo_data;
  logic [OUT_W-1:0] out_bits;

  assign qb_data  = hsl2rgb_mid_t'(qb_bits);
  assign out_data = hsl2rgb_out_t'(out_bits);

  hsl2rgb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .mid_push (fq_push),
    .mid_full (fq_full),
    .mid_data (fq_data)
  );

  // The decoupling queue lets the front keep accepting while the back waits on the receiver.
  hsl2rgb_queue #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .full  (fq_full),
    .wdata (MID_W'(fq_data)),
    .pop   (qb_pop),
    .empty (qb_empty),
    .rdata (qb_bits)
  );

  hsl2rgb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (qb_empty),
    .mid_pop   (qb_pop),
    .mid_data  (qb_data),
    .out_push  (bo_push),
    .out_full  (bo_full),
    .out_data  (bo_data)
  );

  // Finished results wait here so the back end keeps moving while out_pop is low.
  hsl2rgb_queue #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bo_push),
    .full  (bo_full),
    .wdata (OUT_W'(bo_data)),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_bits)
  );

endmodule

### hw/rtl/hsl2rgb_checker.sv
// Port-level checker of the HSL to RGB converter and its bind to the top level.
// Depends on hsl2rgb_pkg and the macros in hsl_to_rgb_converter_assert.svh.
`include "hsl_to_rgb_converter_assert.svh"

module hsl2rgb_checker
  import hsl2rgb_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_push,
  input logic         in_full,
  input hsl2rgb_in_t  in_data,
  input logic         out_empty,
  input logic         out_pop,
  input hsl2rgb_out_t out_data
);

  // Reset leaves no result behind and the input side open.
  `HSL2RGB_ASSERT_NEXT(a_reset_empties, !rst_n, out_empty, "result left after reset")
  `HSL2RGB_ASSERT_NEXT(a_reset_opens, !rst_n, !in_full, "input blocked after reset")

  // Every channel of a waiting result lies within 0..1.0.
  `HSL2RGB_ASSERT_SAME(a_range, !out_empty,
    (out_data.red <= ONE) && (out_data.green <= ONE) && (out_data.blue <= ONE),
    "result channel above full scale")

  // A result that is not taken stays on the ports unchanged.
  `HSL2RGB_ASSERT_NEXT(a_hold, rst_n && !out_empty && !out_pop,
    !out_empty && $stable(out_data), "stalled result changed")

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_checker (.*);

### tb/testbench.sv
// Self-checking testbench for hsl_to_rgb_converter: a directed pixel table, then random pixels.
// Depends on hsl2rgb_pkg for the beat types and the fixed-point constants of the block.
module testbench;
  import hsl2rgb_pkg::*;

  // Generous bound on the whole run. The slowest correct run is about 1500 pixels with
  // both sides idling, so this is far beyond it.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PIXELS = 1500;
  localparam int IDLE_PERCENT = 31;
  localparam int REPORT_LIMIT = 10;
  // Extra clocks to settle after the last expected result has been taken.
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    hsl2rgb_in_t  px;
    bit           known;
    hsl2rgb_out_t rgb;
  } pixel_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_push = 1'b0;
  logic         in_full;
  hsl2rgb_in_t  in_data = '0;
  logic         out_empty;
  logic         out_pop = 1'b0;
  hsl2rgb_out_t out_data;

  pixel_row_t   pixel_rows[$];
  hsl2rgb_out_t expected_rgb[$];
  int           pixels_sent = 0;
  int           pixels_seen = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  always #5 clk = ~clk;

  hsl_to_rgb_converter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  // Rounds a product back to FRAC_BITS fractional bits, half up.
  function automatic longint unsigned round_frac(input longint unsigned x);
    round_frac = (x + HALF) >> FRAC_BITS;
  endfunction

  // Piecewise hue ramp: rises over the first sixth of a turn, holds q up to a half,
  // falls to p by two thirds, then holds p.
  function automatic longint unsigned hue_ramp(input longint unsigned p,
                                               input longint unsigned q,
                                               input longint unsigned t);
    longint unsigned span;
    span = q - p;
    if (t < SIXTH) hue_ramp = p + round_frac(span * 6 * t);
    else if (t < HALF) hue_ramp = q;
    else if (t < TWO_THIRDS) hue_ramp = p + round_frac(span * 6 * (TWO_THIRDS - t));
    else hue_ramp = p;
  endfunction

  // Computes the RGB pixel the converter must return for one HSL pixel. The arithmetic is
  // carried in 64 bits so that any wrap of p behaves the same as in the fixed-point spec.
  function automatic hsl2rgb_out_t predict_rgb(input hsl2rgb_in_t px);
    longint unsigned h, s, l, q, p, t_red, t_blue;
    longint unsigned chan[3];
    hsl2rgb_out_t rgb;
    h = px.hue;
    s = (px.saturation > ONE) ? ONE : px.saturation;
    l = (px.lightness > ONE) ? ONE : px.lightness;
    if (s == 0) begin
      chan[0] = l;
      chan[1] = l;
      chan[2] = l;
    end else begin
      if (l < HALF) q = round_frac(l * (ONE + s));
      else q = l + s - round_frac(l * s);
      p = 2 * l - q;
      // Red sits a third of a turn ahead, blue a third behind, both wrapped into one turn.
      t_red = h + THIRD;
      if (t_red >= ONE) t_red = t_red - ONE;
      t_blue = (h >= THIRD) ? (h - THIRD) : (h + ONE - THIRD);
      chan[0] = hue_ramp(p, q, t_red);
      chan[1] = hue_ramp(p, q, h);
      chan[2] = hue_ramp(p, q, t_blue);
    end
    for (int i = 0; i < 3; i++) begin
      if (chan[i] > ONE) chan[i] = ONE;
    end
    rgb.red = unit_t'(chan[0]);
    rgb.green = unit_t'(chan[1]);
    rgb.blue = unit_t'(chan[2]);
    predict_rgb = rgb;
  endfunction

  // Appends one row to the directed table. When known is set the expected pixel is given
  // here; otherwise the predictor supplies it when the beat is accepted.
  function automatic void add_row(input int h, input int s, input int l, input bit known,
                                  input int r = 0, input int g = 0, input int b = 0);
    pixel_row_t row;
    row.px.hue = hue_t'(h);
    row.px.saturation = unit_t'(s);
    row.px.lightness = unit_t'(l);
    row.known = known;
    row.rgb.red = unit_t'(r);
    row.rgb.green = unit_t'(g);
    row.rgb.blue = unit_t'(b);
    pixel_rows.push_back(row);
  endfunction

  // Offers one pixel, with a random number of idle cycles ahead of it, and records the
  // expected result once the beat is taken. in_push gets exactly one assignment per step:
  // after a beat is taken the next call either lowers it for a gap or keeps it high.
  task automatic send_pixel(input hsl2rgb_in_t px, input bit known, input hsl2rgb_out_t rgb);
    bit calm;
    // A long stretch in the middle of the random part runs with no input gaps at all.
    calm = (pixels_sent >= 600) && (pixels_sent < 900);
    while (!calm && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_full);
    expected_rgb.push_back(known ? rgb : predict_rgb(px));
    pixels_sent++;
  endtask

  // Result side: checks each beat taken at this edge against the oldest expectation, then
  // decides whether to pop at the next edge. The no-stall window is placed on the count of
  // results so that it overlaps, but does not match, the calm window of the input side.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        pixels_seen++;
        if (expected_rgb.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result beat: r=%0d g=%0d b=%0d",
                     out_data.red, out_data.green, out_data.blue);
        end else begin
          hsl2rgb_out_t want;
          want = expected_rgb.pop_front();
          if (out_data.red !== want.red || out_data.green !== want.green ||
              out_data.blue !== want.blue) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result %0d mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       pixels_seen, want.red, want.green, want.blue,
                       out_data.red, out_data.green, out_data.blue);
          end
        end
      end
      if ((pixels_seen >= 700) && (pixels_seen < 1000)) out_pop <= 1'b1;
      else out_pop <= ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Watchdog: a hang on either handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_rgb.size());
      $display("** hsl_to_rgb_converter: FAILED **");
      $finish;
    end
  end

  initial begin
    hsl2rgb_in_t  px;
    hsl2rgb_out_t none;
    int unsigned  pick;

    none = '0;

    // Gray pixels: zero saturation returns the lightness on every channel, and a
    // lightness above one is saturated to one first.
    add_row(0, 0, 0, 1'b1, 0, 0, 0);
    add_row(4095, 0, 4096, 1'b1, 4096, 4096, 4096);
    add_row(2048, 0, 8191, 1'b1, 4096, 4096, 4096);
    add_row(100, 0, 1234, 1'b1, 1234, 1234, 1234);
    // Fully saturated primaries at mid lightness, then white and black.
    add_row(0, 4096, 2048, 1'b1, 4096, 0, 0);
    add_row(1365, 4096, 2048, 1'b1, 0, 4096, 0);
    add_row(2730, 4096, 2048, 1'b1, 0, 0, 4096);
    add_row(0, 4096, 4096, 1'b1, 4096, 4096, 4096);
    add_row(0, 4096, 0, 1'b1, 0, 0, 0);
    // Red position landing exactly on one turn and wrapping to zero.
    add_row(2731, 4096, 2048, 1'b0);
    add_row(4095, 3000, 2500, 1'b0);
    // Blue position going below zero and wrapping up by one turn.
    add_row(0, 1000, 3000, 1'b0);
    add_row(1364, 3000, 1000, 1'b0);
    // Saturation and lightness above one are saturated before use.
    add_row(500, 8191, 2047, 1'b0);
    add_row(3000, 4097, 4097, 1'b0);
    add_row(1200, 8191, 8191, 1'b0);
    // Ramp segment edges around a sixth, a half and two thirds.
    add_row(681, 2048, 1500, 1'b0);
    add_row(682, 2048, 1500, 1'b0);
    add_row(2047, 3333, 2049, 1'b0);
    add_row(2729, 3333, 2049, 1'b0);
    // Smallest nonzero saturation and lightness at either side of a half.
    add_row(3413, 1, 4095, 1'b0);
    add_row(1, 1, 1, 1'b0);
    add_row(2222, 4096, 2049, 1'b0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (pixel_rows[i]) send_pixel(pixel_rows[i].px, pixel_rows[i].known, pixel_rows[i].rgb);

    // Random pixels. Saturation and lightness mostly stay in range, with zero saturation,
    // exact one and out-of-range values mixed in so that every bit of every field toggles.
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      px.hue = hue_t'($urandom_range(ONE - 1));
      pick = $urandom_range(99);
      if (pick < 10) px.saturation = '0;
      else if (pick < 18) px.saturation = unit_t'($urandom_range(8191, ONE + 1));
      else if (pick < 25) px.saturation = ONE;
      else px.saturation = unit_t'($urandom_range(ONE));
      pick = $urandom_range(99);
      if (pick < 8) px.lightness = unit_t'($urandom_range(8191, ONE + 1));
      else if (pick < 11) px.lightness = ONE;
      else if (pick < 14) px.lightness = '0;
      else px.lightness = unit_t'($urandom_range(ONE));
      send_pixel(px, 1'b0, none);
    end
    in_push <= 1'b0;

    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_rgb.size() == 0) begin
      $display("** hsl_to_rgb_converter: PASSED **");
    end else begin
      $display("** hsl_to_rgb_converter: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/hsl2rgb_pkg.sv
hw/rtl/hsl2rgb_queue.sv
hw/rtl/hsl2rgb_front.sv
hw/rtl/hsl2rgb_back.sv
hw/rtl/hsl_to_rgb_converter.sv
hw/rtl/hsl2rgb_checker.sv
tb/testbench.sv
